// ===== hw/rtl/owerq_pkg.sv =====
// ----------------------------------------------------------------------------
// owerq_pkg
// Shared types and constants of the one-way elevator request queue.
// ----------------------------------------------------------------------------
package owerq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 8;

  localparam int BLOCK_W = 32;
  localparam int TAG_W   = 8;
  localparam int OCC_W   = 5;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic               action;
    logic [BLOCK_W-1:0] block_number;
    logic               ordered;
    logic [TAG_W-1:0]   request_tag;
  } request_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [BLOCK_W-1:0] served_block;
    logic [TAG_W-1:0]   served_tag;
    logic [OCC_W-1:0]   occupancy;
  } result_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  block_number;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     capture;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/owerq_cell.sv =====
// ----------------------------------------------------------------------------
// owerq_cell
// One queue slot: holds a request, compares it against an incoming block
// number and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module owerq_cell (
  input  logic                             clk,
  input  owerq_pkg::cell_ctl_t             ctl,
  input  logic [owerq_pkg::BLOCK_W-1:0]    probe_block,
  input  owerq_pkg::entry_t                load_entry,
  input  owerq_pkg::entry_t                prev_entry,
  input  owerq_pkg::entry_t                next_entry,
  output owerq_pkg::entry_t                entry,
  output logic                             probe_lt,
  output logic                             probe_gt
);
  import owerq_pkg::*;

  // The compare flags are taken when an item is accepted and used in the
  // next cycle to place the request.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      probe_lt <= (probe_block < entry.block_number);
      probe_gt <= (probe_block > entry.block_number);
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD:      entry <= load_entry;
      CELL_FROM_PREV: entry <= prev_entry;
      CELL_FROM_NEXT: entry <= next_entry;
      default:        entry <= entry;
    endcase
  end

endmodule

// ===== hw/rtl/one_way_elevator_request_queue.sv =====
// ----------------------------------------------------------------------------
// one_way_elevator_request_queue
// Disk request queue kept in one-way scan order in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage: drive request and raise start while busy is low; the item is taken
// at that clock edge. Each item is an insert (sorted into the primary run,
// the secondary run behind the last served block, or after the lock point
// of an ordered request) or a remove of the head request.
// Every cell compares its stored block number with the incoming one in the
// accept cycle; in the next cycle the insert position is found from those
// flags and all cells shift at once. Busy is high for one cycle after the
// accept, and the result is on result with done high for exactly one cycle,
// starting at the edge that ends the busy cycle.
// A new item can be accepted at the edge that ends the done cycle.
// The receiver cannot stall; each result must be taken in its done cycle.
// A synchronous reset empties the queue and clears the switch point, the
// lock point and the last served position; stored entries are not cleared.
// ----------------------------------------------------------------------------
module one_way_elevator_request_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  owerq_pkg::request_t  request,
  output logic                 busy,
  output logic                 done,
  output owerq_pkg::result_t   result
);
  import owerq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  request_t               req;
  logic                   below_last;
  logic [CNT_W-1:0]       count, count_next;
  logic [IDX_W-1:0]       second_run_start, second_run_start_next;
  logic                   second_run_valid, second_run_valid_next;
  logic [IDX_W-1:0]       lock_position, lock_position_next;
  logic                   lock_valid, lock_valid_next;
  logic [BLOCK_W-1:0]     last_position, last_position_next;

  entry_t                 cell_entry [QUEUE_DEPTH];
  cell_ctl_t              cell_ctl   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] lt_flag, gt_flag;
  entry_t                 load_entry;

  logic                   accept;
  logic                   do_insert, do_remove;
  logic [IDX_W-1:0]       pos;
  result_t                result_next;

  assign accept     = start && (state == S_IDLE);
  assign busy       = (state == S_EXEC);
  assign do_insert  = (state == S_EXEC) && (req.action == ACT_INSERT) &&
                      (count != CNT_W'(QUEUE_DEPTH));
  assign do_remove  = (state == S_EXEC) && (req.action == ACT_REMOVE) &&
                      (count != '0);
  assign load_entry = '{block_number: req.block_number,
                        tag:          TAG_BITS'(req.request_tag)};

  // Cell row.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    if (i == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid_prev
      assign prev_e = cell_entry[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid_next
      assign next_e = cell_entry[i+1];
    end

    owerq_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[i]),
      .probe_block (request.block_number),
      .load_entry  (load_entry),
      .prev_entry  (prev_e),
      .next_entry  (next_e),
      .entry       (cell_entry[i]),
      .probe_lt    (lt_flag[i]),
      .probe_gt    (gt_flag[i])
    );
  end

  // Insert position and mark updates.
  always_comb begin
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] hit_idx;
    logic             hit_found;
    logic             scan;

    n_idx     = IDX_W'(count);
    last_idx  = IDX_W'(count - CNT_W'(1));
    start_idx = '0;
    tail_idx  = last_idx;
    scan      = 1'b0;
    pos       = n_idx;

    if (count == '0 || req.ordered) begin
      pos = n_idx;
    end else if (lock_valid) begin
      start_idx = lock_position;
      scan      = 1'b1;
    end else if (below_last) begin
      if (!second_run_valid) begin
        pos = n_idx;
      end else if (lt_flag[second_run_start]) begin
        pos = second_run_start;
      end else begin
        start_idx = second_run_start;
        scan      = 1'b1;
      end
    end else begin
      if (second_run_valid && second_run_start != '0) begin
        tail_idx = second_run_start - IDX_W'(1);
      end
      if (lt_flag[0]) begin
        pos = '0;
      end else begin
        scan = 1'b1;
      end
    end

    // Lowest slot after the start that ends the run or holds a larger block.
    hit_idx   = n_idx;
    hit_found = 1'b0;
    for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
      if (IDX_W'(k) > start_idx && CNT_W'(k) < count &&
          ((second_run_valid && IDX_W'(k) == second_run_start) || lt_flag[k])) begin
        hit_idx   = IDX_W'(k);
        hit_found = 1'b1;
      end
    end

    if (scan) begin
      if (gt_flag[tail_idx]) begin
        pos = tail_idx + IDX_W'(1);
      end else if (hit_found) begin
        pos = hit_idx;
      end else begin
        pos = n_idx;
      end
    end

    state_next            = state;
    count_next            = count;
    second_run_start_next = second_run_start;
    second_run_valid_next = second_run_valid;
    lock_position_next    = lock_position;
    lock_valid_next       = lock_valid;
    last_position_next    = last_position;
    result_next           = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        if (req.action == ACT_INSERT) begin
          if (do_insert) begin
            result_next.status = ST_INSERTED;
            count_next         = count + CNT_W'(1);
            // Marks at or after the new slot move one place back.
            if (second_run_valid && second_run_start >= pos) begin
              second_run_start_next = second_run_start + IDX_W'(1);
            end
            if (lock_valid && lock_position >= pos) begin
              lock_position_next = lock_position + IDX_W'(1);
            end
            if (count != '0 && req.ordered) begin
              lock_valid_next       = 1'b1;
              lock_position_next    = n_idx;
              second_run_valid_next = 1'b0;
              second_run_start_next = '0;
            end else if (count == '0 && req.ordered) begin
              lock_valid_next       = 1'b1;
              lock_position_next    = n_idx;
              second_run_valid_next = 1'b0;
              second_run_start_next = '0;
            end else if (count != '0 && !lock_valid && below_last) begin
              // A block behind the last position opens the secondary run if none is
              // open, or heads it if it is below the run's first block.
              if (!second_run_valid) begin
                second_run_valid_next = 1'b1;
                second_run_start_next = n_idx;
              end else if (lt_flag[second_run_start]) begin
                second_run_start_next = second_run_start;
              end
            end
          end else begin
            result_next.status = ST_FULL;
          end
        end else begin
          if (do_remove) begin
            result_next.status       = ST_REMOVED;
            result_next.served_block = cell_entry[0].block_number;
            result_next.served_tag   = TAG_W'(cell_entry[0].tag);
            last_position_next       = cell_entry[0].block_number;
            count_next               = count - CNT_W'(1);
            if (lock_valid) begin
              if (lock_position == '0) begin
                lock_valid_next    = 1'b0;
                lock_position_next = '0;
              end else begin
                lock_position_next = lock_position - IDX_W'(1);
              end
            end
            if (second_run_valid) begin
              if (second_run_start <= IDX_W'(1)) begin
                second_run_valid_next = 1'b0;
                second_run_start_next = '0;
              end else begin
                second_run_start_next = second_run_start - IDX_W'(1);
              end
            end
          end else begin
            result_next.status = ST_EMPTY;
          end
        end
        result_next.occupancy = OCC_W'(count_next);
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Per-cell shift control.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_ctl[i].capture = accept;
      cell_ctl[i].op      = CELL_HOLD;
      if (do_remove) begin
        cell_ctl[i].op = CELL_FROM_NEXT;
      end else if (do_insert) begin
        if (IDX_W'(i) == pos) begin
          cell_ctl[i].op = CELL_LOAD;
        end else if (IDX_W'(i) > pos) begin
          cell_ctl[i].op = CELL_FROM_PREV;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      done             <= 1'b0;
      count            <= '0;
      second_run_start <= '0;
      second_run_valid <= 1'b0;
      lock_position    <= '0;
      lock_valid       <= 1'b0;
      last_position    <= '0;
    end else begin
      state            <= state_next;
      done             <= (state == S_EXEC);
      count            <= count_next;
      second_run_start <= second_run_start_next;
      second_run_valid <= second_run_valid_next;
      lock_position    <= lock_position_next;
      lock_valid       <= lock_valid_next;
      last_position    <= last_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req        <= request;
      below_last <= (request.block_number < last_position);
    end
    if (state == S_EXEC) begin
      result <= result_next;
    end
  end

endmodule

// ===== bench/one_way_elevator_request_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_way_elevator_request_queue_tb
// Self-checking bench for the one-way elevator request queue. A short table
// of directed items walks the special cases: empty remove, full insert,
// switch point creation and clearing, ordered lock and lock release. A
// random stream of inserts and removes follows, with the insert bias and
// sender gaps varied by phase. A scan order model predicts every result that the table does not type in.
// ----------------------------------------------------------------------------
module one_way_elevator_request_queue_tb;
  import owerq_pkg::*;

  localparam int NUM_ROWS     = 25;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 99;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    request_t rq;
    int       reps;
    bit       has_res;
    result_t  res;
  } row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  // Sideband of the stimulus: a result typed into the directed table.
  bit       typed_valid = 1'b0;
  result_t  typed_result = '0;

  result_t  pending_results [$];
  int       mismatches = 0;
  int       cycles = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;

  // Scan order model state.
  logic [BLOCK_W-1:0]  q_block [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] q_tag [QUEUE_DEPTH];
  int                  q_count = 0;
  int                  switch_idx = 0;
  bit                  switch_on = 1'b0;
  int                  lock_idx = 0;
  bit                  lock_on = 1'b0;
  logic [BLOCK_W-1:0]  last_served = '0;

  row_t stim_rows [NUM_ROWS] = '{
    '{'{ACT_REMOVE, 32'h0000_0000, 1'b0, 8'h00}, 1, 1'b1, '{ST_EMPTY, 32'h0, 8'h00, 5'd0}},
    '{'{ACT_INSERT, 32'h0000_1000, 1'b0, 8'h00}, 1, 1'b1,
      '{ST_INSERTED, 32'h0, 8'h00, 5'd1}},
    '{'{ACT_INSERT, 32'hFFFF_FFFF, 1'b0, 8'hFF}, 1, 1'b1,
      '{ST_INSERTED, 32'h0, 8'h00, 5'd2}},
    '{'{ACT_INSERT, 32'h0000_0000, 1'b0, 8'h11}, 1, 1'b0, '0},
    '{'{ACT_REMOVE, 32'h0000_0000, 1'b0, 8'h00}, 1, 1'b1,
      '{ST_REMOVED, 32'h0, 8'h11, 5'd2}},
    '{'{ACT_REMOVE, 32'hFFFF_FFFF, 1'b1, 8'hFF}, 1, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_0800, 1'b0, 8'h22}, 1, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_0400, 1'b0, 8'h33}, 1, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_0600, 1'b0, 8'h44}, 1, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_2000, 1'b0, 8'h55}, 1, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_0100, 1'b1, 8'h66}, 1, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_0050, 1'b0, 8'h77}, 1, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_3000, 1'b0, 8'h88}, 1, 1'b0, '0},
    '{'{ACT_REMOVE, 32'h0000_0000, 1'b0, 8'h00}, 8, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_4000, 1'b0, 8'h99}, 1, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_1000, 1'b0, 8'hAA}, 1, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_0900, 1'b0, 8'hBB}, 1, 1'b0, '0},
    '{'{ACT_REMOVE, 32'h0000_0000, 1'b0, 8'h00}, 1, 1'b0, '0},
    '{'{ACT_REMOVE, 32'h0000_0000, 1'b0, 8'h00}, 2, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_5000, 1'b0, 8'hCC}, 16, 1'b0, '0},
    '{'{ACT_INSERT, 32'h0000_6000, 1'b0, 8'hDD}, 1, 1'b1,
      '{ST_FULL, 32'h0, 8'h00, 5'd16}},
    '{'{ACT_REMOVE, 32'h0000_0000, 1'b0, 8'h00}, 16, 1'b0, '0},
    '{'{ACT_REMOVE, 32'h0000_0000, 1'b0, 8'h00}, 1, 1'b1, '{ST_EMPTY, 32'h0, 8'h00, 5'd0}},
    '{'{ACT_INSERT, 32'h7FFF_FFFF, 1'b1, 8'hEE}, 1, 1'b0, '0},
    '{'{ACT_REMOVE, 32'h0000_0000, 1'b0, 8'h00}, 1, 1'b0, '0}
  };

  one_way_elevator_request_queue dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always #2 clk = ~clk;

  // Opens a slot at pos and moves the marks at or after it along.
  function automatic void shift_in(input int pos, input logic [BLOCK_W-1:0] blk,
                                   input logic [TAG_BITS-1:0] tag);
    for (int i = q_count; i > pos; i--) begin
      q_block[i] = q_block[i-1];
      q_tag[i]   = q_tag[i-1];
    end
    q_block[pos] = blk;
    q_tag[pos]   = tag;
    q_count++;
    if (switch_on && switch_idx >= pos) switch_idx++;
    if (lock_on && lock_idx >= pos) lock_idx++;
  endfunction

  function automatic void sort_in(input logic [BLOCK_W-1:0] blk, input logic ord,
                                  input logic [TAG_BITS-1:0] tag);
    int tail;
    int first;
    int j;
    if (q_count == 0 || ord) begin
      shift_in(q_count, blk, tag);
      if (ord) begin
        lock_on    = 1'b1;
        lock_idx   = q_count - 1;
        switch_on  = 1'b0;
        switch_idx = 0;
      end
      return;
    end
    tail = q_count - 1;
    if (lock_on) begin
      first = lock_idx;
    end else if (blk < last_served) begin
      if (!switch_on) begin
        shift_in(q_count, blk, tag);
        switch_on  = 1'b1;
        switch_idx = q_count - 1;
        return;
      end
      first = switch_idx;
      if (blk < q_block[first]) begin
        // The new request takes over the switch point at the same index.
        switch_on = 1'b0;
        shift_in(first, blk, tag);
        switch_on = 1'b1;
        return;
      end
    end else begin
      first = 0;
      if (switch_on && switch_idx > 0) tail = switch_idx - 1;
      if (blk < q_block[0]) begin
        shift_in(0, blk, tag);
        return;
      end
    end
    if (blk > q_block[tail]) begin
      shift_in(tail + 1, blk, tag);
      return;
    end
    j = first;
    while (j + 1 < q_count) begin
      if (switch_on && j + 1 == switch_idx) break;
      if (blk < q_block[j+1]) break;
      j++;
    end
    shift_in(j + 1, blk, tag);
  endfunction

  function automatic result_t scan_order_step(input request_t rq);
    result_t r;
    r = '0;
    if (rq.action == ACT_INSERT) begin
      if (q_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        sort_in(rq.block_number, rq.ordered, rq.request_tag[TAG_BITS-1:0]);
        r.status = ST_INSERTED;
      end
    end else if (q_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status       = ST_REMOVED;
      r.served_block = q_block[0];
      r.served_tag   = TAG_W'(q_tag[0]);
      last_served    = q_block[0];
      for (int i = 1; i < q_count; i++) begin
        q_block[i-1] = q_block[i];
        q_tag[i-1]   = q_tag[i];
      end
      q_count--;
      if (lock_on) begin
        if (lock_idx == 0) begin
          lock_on  = 1'b0;
          lock_idx = 0;
        end else begin
          lock_idx--;
        end
      end
      if (switch_on) begin
        if (switch_idx <= 1) begin
          switch_on  = 1'b0;
          switch_idx = 0;
        end else begin
          switch_idx--;
        end
      end
    end
    r.occupancy = OCC_W'(q_count);
    return r;
  endfunction

  // Block numbers mostly come from a narrow window so that ties and the
  // behind/ahead decision against the last served block happen often.
  function automatic request_t random_request(input int insert_pct);
    request_t rq;
    rq.action       = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
    rq.block_number = ($urandom_range(3) == 0) ? $urandom : $urandom_range(63);
    rq.ordered      = ($urandom_range(11) == 0);
    rq.request_tag  = TAG_W'($urandom);
    return rq;
  endfunction

  task automatic flag_mismatch(input string why, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t mismatch (%s): expected status=%0d block=%h tag=%h occ=%0d, ",
             $time, why, want.status, want.served_block, want.served_tag, want.occupancy);
      $display("got status=%0d block=%h tag=%h occ=%0d",
               got.status, got.served_block, got.served_tag, got.occupancy);
    end
  endtask

  // Holds the item until it is taken, then maybe pauses between bursts.
  task automatic send_item(input request_t rq, input bit has_res, input result_t res);
    start        <= 1'b1;
    request      <= rq;
    typed_valid  <= has_res;
    typed_result <= res;
    do @(posedge clk); while (busy);
    if (burst_left > 0 || !gaps_on) begin
      if (burst_left > 0) burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result", '0, result);
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status || result.served_block !== want.served_block ||
              result.served_tag !== want.served_tag || result.occupancy !== want.occupancy)
            flag_mismatch("field", want, result);
        end
      end
      if (start && !busy) begin
        want = scan_order_step(request);
        if (typed_valid) want = typed_result;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("one_way_elevator_request_queue regression: fail");
      $finish;
    end
  end

  initial begin
    int insert_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[r])
      for (int k = 0; k < stim_rows[r].reps; k++)
        send_item(stim_rows[r].rq, stim_rows[r].has_res, stim_rows[r].res);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case ($urandom_range(3))
        0: insert_pct = 30;
        1: insert_pct = 50;
        2: insert_pct = 62;
        default: insert_pct = 80;
      endcase
      gaps_on = (phase % 3 != 1);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(random_request(insert_pct), 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_results.size() != 0) begin
      flag_mismatch("missing result", pending_results.pop_front(), '0);
    end

    if (mismatches == 0) begin
      $display("one_way_elevator_request_queue regression: pass");
    end else begin
      $display("one_way_elevator_request_queue regression: fail");
    end
    $finish;
  end

endmodule
